[design/descending_sorter_assert.svh]
// assertion macros used by the sorter rtl
`ifndef DESCENDING_SORTER_ASSERT_SVH
`define DESCENDING_SORTER_ASSERT_SVH

// same-cycle implication, skipped while in reset
`define DS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorter check failed");

// next-cycle implication, skipped while in reset
`define DS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorter check failed");

`endif

[design/ds_pkg.sv]
// shared constants and types for the descending sorter
`timescale 1ns / 1ps

package ds_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 16;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // what one cell shows its neighbors
  typedef struct packed {
    value_t value;
    logic   valid;
    logic   keep;   // holds a value >= the one being inserted
  } cell_link_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

[design/descending_sorter.sv]
// descending_sorter: streaming insertion sorter built as a chain of cells
//
// input channel (value, last, in_valid/in_ready): one value per request. each
// request is inserted into the chain as it is accepted; the chain holds up to
// CAPACITY values in descending order, later equal values behind earlier ones.
// values arriving when the chain is full are dropped and mark the run overflowed.
// a request with last set starts the output after its own insertion.
// output channel (sorted_value, end_of_run, overflow, out_valid/out_ready):
// the head cell drives the outputs; every accepted result shifts the whole chain
// one cell toward the head. end_of_run marks the smallest value, overflow is
// set on every result of a run that dropped values.
// timing: first result is valid the cycle after the last request is accepted,
// then one result per cycle while out_ready is high. input takes one request
// per cycle while filling; in_ready is low during the drain, so no request of
// the next run is taken until the last result is accepted. a stalled receiver
// simply holds the chain. reset empties the chain and clears the overflow mark.
`timescale 1ns / 1ps

module descending_sorter
  import ds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] sorted_value,
  output logic                  end_of_run,
  output logic                  overflow
);

`include "descending_sorter_assert.svh"

  typedef enum logic {ST_FILL, ST_DRAIN} state_t;

  state_t     state;
  count_t     stored_count;
  logic       dropped_flag;
  logic       in_fire;
  logic       out_fire;
  logic       full;
  cell_ctrl_t ctrl;
  cell_link_t links [CAPACITY];

  localparam count_t CapacityCount = COUNT_BITS'(CAPACITY);
  localparam count_t OneCount      = COUNT_BITS'(1);

  assign in_ready  = (state == ST_FILL);
  assign out_valid = (state == ST_DRAIN);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign full      = (stored_count == CapacityCount);

  assign ctrl = '{insert: in_fire && !full, shift: out_fire};

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      cell_link_t prev_link;
      cell_link_t next_link;

      if (i == 0) begin : g_head
        assign prev_link = '{value: '0, valid: 1'b1, keep: 1'b1};
      end else begin : g_prev
        assign prev_link = links[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign next_link = '{value: '0, valid: 1'b0, keep: 1'b0};
      end else begin : g_next
        assign next_link = links[i+1];
      end

      ds_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .new_value (value),
        .prev_link (prev_link),
        .next_link (next_link),
        .link      (links[i])
      );
    end
  endgenerate

  assign sorted_value = links[0].value;
  assign end_of_run   = !links[1].valid;
  assign overflow     = dropped_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FILL;
      stored_count <= '0;
      dropped_flag <= 1'b0;
    end else begin
      unique case (state)
        ST_FILL: begin
          if (in_fire) begin
            if (full) begin
              dropped_flag <= 1'b1;
            end else begin
              stored_count <= stored_count + OneCount;
            end
            if (last) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_fire) begin
            stored_count <= stored_count - OneCount;
            if (stored_count == OneCount) begin
              state        <= ST_FILL;
              dropped_flag <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_FILL;
        end
      endcase
    end
  end

  `DS_ASSERT_NOW(a_drain_not_empty, clk, rst, out_valid, stored_count != '0)
  `DS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, stored_count <= CapacityCount)
  `DS_ASSERT_NOW(a_end_matches_count, clk, rst, out_valid,
                 end_of_run == (stored_count == OneCount))
  `DS_ASSERT_NEXT(a_last_starts_drain, clk, rst, in_fire && last, out_valid)
  `DS_ASSERT_NEXT(a_run_closes, clk, rst, out_fire && end_of_run,
                  in_ready && !overflow)

endmodule

[design/ds_cell.sv]
// one cell of the insertion chain: holds a value, inserts or shifts toward the head
`timescale 1ns / 1ps

module ds_cell
  import ds_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  value_t     new_value,
  input  cell_link_t prev_link,
  input  cell_link_t next_link,
  output cell_link_t link
);

  value_t value;
  logic   valid;
  logic   keep;

  assign keep = valid && (value >= new_value);
  assign link = '{value: value, valid: valid, keep: keep};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next_link.valid;
    end else if (ctrl.insert && !keep) begin
      valid <= prev_link.keep ? 1'b1 : prev_link.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= next_link.value;
    end else if (ctrl.insert && !keep) begin
      // first cell below the insertion point takes the new value, the rest move down
      value <= prev_link.keep ? new_value : prev_link.value;
    end
  end

endmodule
